// ===== rtl/btxp_pkg.sv =====
// btxp_pkg: shared constants and types for the transaction stream parser.
// No dependencies; used by every other file in rtl/.
package btxp_pkg;

	localparam int COUNT_BITS = 16;
	localparam int DATA_W     = 8;
	localparam int KIND_W     = 3;
	localparam int VALUE_W    = 64;
	localparam int ENTRY_W    = 16;
	localparam int LIMIT_W    = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int PHASE_W    = 4;
	localparam int BIF_W      = 6;
	localparam int VLEFT_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_INPUT_LIMIT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT = 1'd1;

	localparam logic [LIMIT_W-1:0] INPUT_LIMIT_RST  = 16'd2500;
	localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 16'd12000;

	localparam logic [DATA_W-1:0] VARINT_16 = 8'hFD;
	localparam logic [DATA_W-1:0] VARINT_32 = 8'hFE;

	localparam logic [PHASE_W-1:0] PH_VERSION    = 4'd0;
	localparam logic [PHASE_W-1:0] PH_IN_COUNT   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_IN_HASH    = 4'd2;
	localparam logic [PHASE_W-1:0] PH_IN_INDEX   = 4'd3;
	localparam logic [PHASE_W-1:0] PH_IN_SLEN    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_IN_SCRIPT  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_IN_SEQ     = 4'd6;
	localparam logic [PHASE_W-1:0] PH_OUT_COUNT  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_OUT_VALUE  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_OUT_SLEN   = 4'd9;
	localparam logic [PHASE_W-1:0] PH_OUT_SCRIPT = 4'd10;
	localparam logic [PHASE_W-1:0] PH_LOCKTIME   = 4'd11;

	localparam logic [KIND_W-1:0] EV_IN_COUNT   = 3'd0;
	localparam logic [KIND_W-1:0] EV_IN_SLEN    = 3'd1;
	localparam logic [KIND_W-1:0] EV_OUT_COUNT  = 3'd2;
	localparam logic [KIND_W-1:0] EV_OUT_VALUE  = 3'd3;
	localparam logic [KIND_W-1:0] EV_OUT_SLEN   = 3'd4;
	localparam logic [KIND_W-1:0] EV_DONE       = 3'd5;
	localparam logic [KIND_W-1:0] EV_BAD_COUNT  = 3'd6;
	localparam logic [KIND_W-1:0] EV_TRUNCATED  = 3'd7;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [VALUE_W-1:0] value;
		logic [ENTRY_W-1:0] entry;
	} event_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] input_limit;
		logic [LIMIT_W-1:0] output_limit;
	} limits_t;

endpackage

// ===== rtl/btxp_if.sv =====
// btxp_if: valid/ready channel interfaces for byte input and event output.
// Depends on btxp_pkg for field widths.
interface btxp_byte_if;
	logic                         valid;
	logic                         ready;
	logic [btxp_pkg::DATA_W-1:0]  data_byte;
	logic                         final_byte;

	modport source (output valid, output data_byte, output final_byte, input ready);
	modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface btxp_evt_if;
	logic                          valid;
	logic                          ready;
	logic [btxp_pkg::KIND_W-1:0]   event_kind;
	logic [btxp_pkg::VALUE_W-1:0]  event_value;
	logic [btxp_pkg::ENTRY_W-1:0]  entry_number;

	modport source (output valid, output event_kind, output event_value,
		output entry_number, input ready);
	modport sink   (input valid, input event_kind, input event_value,
		input entry_number, output ready);
endinterface

// ===== rtl/btxp_cfg.sv =====
// btxp_cfg: limit registers written through the plain configuration port.
// Depends on btxp_pkg.
module btxp_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [btxp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btxp_pkg::LIMIT_W-1:0]    cfg_data,
	output btxp_pkg::limits_t               limits
);
	import btxp_pkg::*;

	limits_t limits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limits_q.input_limit  <= INPUT_LIMIT_RST;
			limits_q.output_limit <= OUTPUT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INPUT_LIMIT:  limits_q.input_limit  <= cfg_data;
				REG_OUTPUT_LIMIT: limits_q.output_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	assign limits = limits_q;

endmodule

// ===== rtl/btxp_core.sv =====
// btxp_core: field walker; parse state registers and per-byte next-state logic.
// Depends on btxp_pkg; limits come from btxp_cfg.
module btxp_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [btxp_pkg::DATA_W-1:0]   data_byte,
	input  logic                          final_byte,
	input  btxp_pkg::limits_t             limits,
	output logic                          have_event,
	output btxp_pkg::event_t              evt
);
	import btxp_pkg::*;

	logic [PHASE_W-1:0]    phase_q, n_phase;
	logic [BIF_W-1:0]      bif_q, n_bif;
	logic [VLEFT_W-1:0]    vleft_q, n_vleft;
	logic [VALUE_W-1:0]    acc_q, n_acc;
	logic [COUNT_BITS-1:0] left_q, n_left;
	logic [COUNT_BITS-1:0] ctr_q, n_ctr;
	logic [VALUE_W-1:0]    sleft_q, n_sleft;
	logic                  skip_q, n_skip;

	// byte merged into the accumulator at the current byte position
	logic [VALUE_W-1:0]    acc_ins;
	// compact-size step
	logic                  v_done;
	logic [VALUE_W-1:0]    v_acc;
	logic [BIF_W-1:0]      v_bif;
	logic [VLEFT_W-1:0]    v_left;
	// fixed-length step
	logic [BIF_W-1:0]      f_len;
	logic [BIF_W-1:0]      f_nb;
	logic                  f_done;
	// entry advance
	logic [COUNT_BITS-1:0] ne_ctr;
	logic [COUNT_BITS-1:0] ne_left;
	logic                  ne_last;
	logic [VALUE_W-1:0]    sleft_dec;
	logic [VALUE_W-1:0]    lim;
	logic                  is_in;

	assign acc_ins   = acc_q | (VALUE_W'(data_byte) << {bif_q[2:0], 3'b000});
	assign ne_ctr    = ctr_q + 1'b1;
	assign ne_left   = left_q - 1'b1;
	assign ne_last   = (ne_left == '0);
	assign sleft_dec = sleft_q - 1'b1;
	assign is_in     = (phase_q == PH_IN_COUNT) || (phase_q == PH_IN_SLEN);
	assign lim       = is_in ? VALUE_W'(limits.input_limit) : VALUE_W'(limits.output_limit);

	always_comb begin
		v_done = 1'b0;
		v_acc  = acc_q;
		v_bif  = bif_q;
		v_left = vleft_q;
		if (vleft_q == '0) begin
			v_bif = '0;
			if (data_byte < VARINT_16) begin
				v_acc  = VALUE_W'(data_byte);
				v_done = 1'b1;
			end else begin
				v_acc  = '0;
				v_left = (data_byte == VARINT_16) ? 4'd2 :
					(data_byte == VARINT_32) ? 4'd4 : 4'd8;
			end
		end else begin
			v_acc  = acc_ins;
			v_left = vleft_q - 1'b1;
			if (v_left == '0) begin
				v_bif  = '0;
				v_done = 1'b1;
			end else begin
				v_bif = bif_q + 1'b1;
			end
		end
	end

	always_comb begin
		unique case (phase_q)
			PH_IN_HASH:   f_len = 6'd32;
			PH_OUT_VALUE: f_len = 6'd8;
			default:      f_len = 6'd4;
		endcase
	end

	assign f_nb   = bif_q + 1'b1;
	assign f_done = (f_nb >= f_len);

	always_comb begin
		n_phase    = phase_q;
		n_bif      = bif_q;
		n_vleft    = vleft_q;
		n_acc      = acc_q;
		n_left     = left_q;
		n_ctr      = ctr_q;
		n_sleft    = sleft_q;
		n_skip     = skip_q;
		have_event = 1'b0;
		evt.kind   = EV_IN_COUNT;
		evt.value  = '0;
		evt.entry  = '0;

		if (!skip_q) begin
			unique case (phase_q)
				PH_VERSION, PH_IN_HASH, PH_IN_INDEX, PH_IN_SEQ, PH_LOCKTIME: begin
					n_bif = f_done ? '0 : f_nb;
					if (f_done) begin
						unique case (phase_q)
							PH_VERSION:  n_phase = PH_IN_COUNT;
							PH_IN_HASH:  n_phase = PH_IN_INDEX;
							PH_IN_INDEX: n_phase = PH_IN_SLEN;
							PH_IN_SEQ: begin
								n_ctr   = ne_ctr;
								n_left  = ne_left;
								n_phase = ne_last ? PH_OUT_COUNT : PH_IN_HASH;
							end
							default: begin
								have_event = 1'b1;
								evt.kind   = EV_DONE;
								n_skip     = 1'b1;
							end
						endcase
					end
				end
				PH_IN_COUNT, PH_OUT_COUNT: begin
					n_acc   = v_acc;
					n_bif   = v_bif;
					n_vleft = v_left;
					if (v_done) begin
						have_event = 1'b1;
						evt.value  = v_acc;
						if ((v_acc == '0) || (v_acc >= lim)) begin
							evt.kind = EV_BAD_COUNT;
							n_skip   = 1'b1;
						end else begin
							evt.kind = is_in ? EV_IN_COUNT : EV_OUT_COUNT;
							n_left   = v_acc[COUNT_BITS-1:0];
							n_ctr    = '0;
							n_acc    = '0;
							n_phase  = is_in ? PH_IN_HASH : PH_OUT_VALUE;
						end
					end
				end
				PH_IN_SLEN, PH_OUT_SLEN: begin
					n_acc   = v_acc;
					n_bif   = v_bif;
					n_vleft = v_left;
					if (v_done) begin
						have_event = 1'b1;
						evt.kind   = is_in ? EV_IN_SLEN : EV_OUT_SLEN;
						evt.value  = v_acc;
						evt.entry  = ENTRY_W'(ctr_q);
						n_sleft    = v_acc;
						n_acc      = '0;
						if (v_acc != '0) begin
							n_phase = is_in ? PH_IN_SCRIPT : PH_OUT_SCRIPT;
						end else if (is_in) begin
							n_phase = PH_IN_SEQ;
						end else begin
							n_ctr   = ne_ctr;
							n_left  = ne_left;
							n_phase = ne_last ? PH_LOCKTIME : PH_OUT_VALUE;
						end
					end
				end
				PH_IN_SCRIPT: begin
					n_sleft = sleft_dec;
					if (sleft_dec == '0)
						n_phase = PH_IN_SEQ;
				end
				PH_OUT_SCRIPT: begin
					n_sleft = sleft_dec;
					if (sleft_dec == '0) begin
						n_ctr   = ne_ctr;
						n_left  = ne_left;
						n_phase = ne_last ? PH_LOCKTIME : PH_OUT_VALUE;
					end
				end
				PH_OUT_VALUE: begin
					n_acc = acc_ins;
					n_bif = f_done ? '0 : f_nb;
					if (f_done) begin
						have_event = 1'b1;
						evt.kind   = EV_OUT_VALUE;
						evt.value  = acc_ins;
						evt.entry  = ENTRY_W'(ctr_q);
						n_acc      = '0;
						n_phase    = PH_OUT_SLEN;
					end
				end
				default: begin
					n_phase = PH_VERSION;
					n_bif   = '0;
					n_vleft = '0;
					n_acc   = '0;
					n_left  = '0;
					n_ctr   = '0;
					n_sleft = '0;
					n_skip  = 1'b0;
				end
			endcase

			// truncation overrides anything but done
			if (final_byte && !(have_event && evt.kind == EV_DONE)) begin
				have_event = 1'b1;
				evt.kind   = EV_TRUNCATED;
				evt.value  = '0;
				evt.entry  = '0;
			end
		end

		if (final_byte) begin
			n_phase = PH_VERSION;
			n_bif   = '0;
			n_vleft = '0;
			n_acc   = '0;
			n_left  = '0;
			n_ctr   = '0;
			n_sleft = '0;
			n_skip  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION;
			bif_q   <= '0;
			vleft_q <= '0;
			acc_q   <= '0;
			left_q  <= '0;
			ctr_q   <= '0;
			sleft_q <= '0;
			skip_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= n_phase;
			bif_q   <= n_bif;
			vleft_q <= n_vleft;
			acc_q   <= n_acc;
			left_q  <= n_left;
			ctr_q   <= n_ctr;
			sleft_q <= n_sleft;
			skip_q  <= n_skip;
		end
	end

endmodule

// ===== rtl/btxp_out_reg.sv =====
// btxp_out_reg: event output register; takes a new event while the held one drains.
// Depends on btxp_pkg.
module btxp_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  btxp_pkg::event_t  evt_in,
	output logic              can_take,
	output logic              valid,
	input  logic              ready,
	output btxp_pkg::event_t  evt_out
);
	import btxp_pkg::*;

	logic   valid_q;
	event_t evt_q;

	assign can_take = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			evt_q <= evt_in;
	end

	assign valid   = valid_q;
	assign evt_out = evt_q;

endmodule

// ===== rtl/bitcoin_tx_stream_parser.sv =====
// bitcoin_tx_stream_parser: top level; byte-serial transaction field walker.
// Depends on btxp_pkg, btxp_if, btxp_cfg, btxp_core, btxp_out_reg.
//
//   port    | role          | payload
//   --------+---------------+----------------------------------------------
//   bytes   | byte sink     | data_byte[7:0], final_byte
//   events  | event source  | event_kind[2:0], event_value[63:0], entry_number[15:0]
//   cfg_*   | register write| cfg_index[0], cfg_data[15:0]
//
// One byte per cycle unless stalled; its event is in the output register next cycle.
// Set by the state update in btxp_core feeding one output register.
// A new byte is taken whenever the output register is empty or drains that cycle.
// A stalled output blocks bytes only while a held event is waiting.
// Reset clears parse state and loads limits 2500 and 12000.
module bitcoin_tx_stream_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [btxp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [btxp_pkg::LIMIT_W-1:0]    cfg_data,
	btxp_byte_if.sink                       bytes,
	btxp_evt_if.source                      events
);
	import btxp_pkg::*;

	limits_t limits;
	logic    can_take;
	logic    accept;
	logic    have_event;
	event_t  evt_new;
	event_t  evt_held;

	assign bytes.ready = can_take;
	assign accept      = bytes.valid && can_take;

	btxp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.limits    (limits)
	);

	btxp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (bytes.data_byte),
		.final_byte (bytes.final_byte),
		.limits     (limits),
		.have_event (have_event),
		.evt        (evt_new)
	);

	btxp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept && have_event),
		.evt_in   (evt_new),
		.can_take (can_take),
		.valid    (events.valid),
		.ready    (events.ready),
		.evt_out  (evt_held)
	);

	assign events.event_kind   = evt_held.kind;
	assign events.event_value  = evt_held.value;
	assign events.entry_number = evt_held.entry;

endmodule

// ===== tb/tb_bitcoin_tx_stream_parser.sv =====
`timescale 1ns / 100ps
// Testbench for bitcoin_tx_stream_parser: streams serialized transactions byte by byte
// and checks each event against a cycle-free parser kept in the testbench.
// Depends on rtl/btxp_pkg.sv, rtl/btxp_if.sv and the parser RTL.
module tb_bitcoin_tx_stream_parser;
	import btxp_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [DATA_W-1:0] VARINT_64 = 8'hFF;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [LIMIT_W-1:0] cfg_data;

	btxp_byte_if byte_ch();
	btxp_evt_if evt_ch();

	bitcoin_tx_stream_parser i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.bytes     (byte_ch),
		.events    (evt_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser state mirrored in the testbench
	logic [LIMIT_W-1:0]    in_limit;
	logic [LIMIT_W-1:0]    out_limit;
	logic [PHASE_W-1:0]    phase;
	logic [BIF_W-1:0]      field_pos;
	logic [VLEFT_W-1:0]    vint_left;
	logic [VALUE_W-1:0]    accum;
	logic [COUNT_BITS-1:0] entries_left;
	logic [COUNT_BITS-1:0] entry_idx;
	logic [VALUE_W-1:0]    script_left;
	bit                    skipping;

	event_t pending_events[$];
	event_t want;
	logic [DATA_W-1:0] tx_buf[$];

	int  mismatches = 0;
	int  cycle_count = 0;
	int  bytes_sent = 0;
	int  rx_wait = 0;
	int  hold_len = 0;
	bit  idle_on = 1'b0;
	int  value_fill = -1;
	int  varint_width = 0;

	function automatic void clear_walk();
		phase        = PH_VERSION;
		field_pos    = '0;
		vint_left    = '0;
		accum        = '0;
		entries_left = '0;
		entry_idx    = '0;
		script_left  = '0;
		skipping     = 1'b0;
	endfunction

	function automatic bit varint_step(input logic [DATA_W-1:0] b);
		if (vint_left == 0) begin
			accum = '0;
			field_pos = '0;
			if (b < VARINT_16) begin
				accum = {56'd0, b};
				return 1'b1;
			end
			vint_left = (b == VARINT_16) ? 4'd2 : (b == VARINT_32) ? 4'd4 : 4'd8;
			return 1'b0;
		end
		accum = accum | ({56'd0, b} << (8 * field_pos[2:0]));
		field_pos = field_pos + 1'b1;
		vint_left = vint_left - 1'b1;
		if (vint_left == 0) begin
			field_pos = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit fixed_step(input int len);
		field_pos = field_pos + 1'b1;
		if (field_pos >= len) begin
			field_pos = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void next_entry(input logic [PHASE_W-1:0] more,
		input logic [PHASE_W-1:0] last);
		entry_idx = entry_idx + 1'b1;
		entries_left = entries_left - 1'b1;
		phase = (entries_left == 0) ? last : more;
	endfunction

	// advance the mirrored parser by one byte and queue the event it owes
	function automatic void walk_tx_byte(input logic [DATA_W-1:0] b, input logic fin);
		event_t ev;
		bit     hit;
		bit     is_in;
		ev  = '0;
		hit = 1'b0;
		if (skipping) begin
			if (fin)
				clear_walk();
			return;
		end
		case (phase)
			PH_VERSION: if (fixed_step(4)) phase = PH_IN_COUNT;
			PH_IN_COUNT, PH_OUT_COUNT: if (varint_step(b)) begin
				is_in = (phase == PH_IN_COUNT);
				hit = 1'b1;
				ev.value = accum;
				if (accum == 0 || accum >= (is_in ? in_limit : out_limit)) begin
					ev.kind = EV_BAD_COUNT;
					skipping = 1'b1;
				end else begin
					ev.kind = is_in ? EV_IN_COUNT : EV_OUT_COUNT;
					entries_left = accum[COUNT_BITS-1:0];
					entry_idx = '0;
					accum = '0;
					phase = is_in ? PH_IN_HASH : PH_OUT_VALUE;
				end
			end
			PH_IN_HASH: if (fixed_step(32)) phase = PH_IN_INDEX;
			PH_IN_INDEX: if (fixed_step(4)) phase = PH_IN_SLEN;
			PH_IN_SLEN, PH_OUT_SLEN: if (varint_step(b)) begin
				is_in = (phase == PH_IN_SLEN);
				hit = 1'b1;
				ev.kind = is_in ? EV_IN_SLEN : EV_OUT_SLEN;
				ev.value = accum;
				ev.entry = entry_idx;
				script_left = accum;
				accum = '0;
				if (script_left != 0)
					phase = is_in ? PH_IN_SCRIPT : PH_OUT_SCRIPT;
				else if (is_in)
					phase = PH_IN_SEQ;
				else
					next_entry(PH_OUT_VALUE, PH_LOCKTIME);
			end
			PH_IN_SCRIPT: begin
				script_left = script_left - 1'b1;
				if (script_left == 0)
					phase = PH_IN_SEQ;
			end
			PH_IN_SEQ: if (fixed_step(4)) next_entry(PH_IN_HASH, PH_OUT_COUNT);
			PH_OUT_VALUE: begin
				accum = accum | ({56'd0, b} << (8 * field_pos[2:0]));
				if (fixed_step(8)) begin
					hit = 1'b1;
					ev.kind = EV_OUT_VALUE;
					ev.value = accum;
					ev.entry = entry_idx;
					accum = '0;
					phase = PH_OUT_SLEN;
				end
			end
			PH_OUT_SCRIPT: begin
				script_left = script_left - 1'b1;
				if (script_left == 0)
					next_entry(PH_OUT_VALUE, PH_LOCKTIME);
			end
			PH_LOCKTIME: if (fixed_step(4)) begin
				hit = 1'b1;
				ev.kind = EV_DONE;
				skipping = 1'b1;
			end
			default: clear_walk();
		endcase
		if (fin) begin
			if (!(hit && ev.kind == EV_DONE)) begin
				hit = 1'b1;
				ev = '0;
				ev.kind = EV_TRUNCATED;
			end
			clear_walk();
		end
		if (hit)
			pending_events.push_back(ev);
	endfunction

	// transaction builders
	function automatic void add_bytes(input int n, input int fill);
		int k;
		for (k = 0; k < n; k++)
			tx_buf.push_back((fill < 0) ? DATA_W'($urandom) : DATA_W'(fill));
	endfunction

	function automatic void add_varint(input logic [63:0] v);
		int w;
		int k;
		w = varint_width;
		if (w == 0) begin
			case ($urandom_range(0, 9))
				0: w = 3;
				1: w = 5;
				2: w = 9;
				default: w = 1;
			endcase
		end
		if (w == 1 && v >= {56'd0, VARINT_16}) w = 3;
		if (w == 3 && v > 64'hFFFF) w = 5;
		if (w == 5 && v > 64'hFFFF_FFFF) w = 9;
		case (w)
			1: tx_buf.push_back(v[7:0]);
			3: tx_buf.push_back(VARINT_16);
			5: tx_buf.push_back(VARINT_32);
			default: tx_buf.push_back(VARINT_64);
		endcase
		for (k = 0; k < w - 1; k++)
			tx_buf.push_back(v[8*k +: 8]);
	endfunction

	function automatic logic [63:0] pick_script_len(input int max_len);
		logic [63:0] len;
		if (max_len < 0 || (max_len > 0 && $urandom_range(0, 24) == 0)) begin
			len = {$urandom, $urandom};
			if (len <= 16)
				len = 64'd17;
			return len;
		end
		return 64'($urandom_range(0, max_len));
	endfunction

	function automatic logic [63:0] pick_count(input logic [LIMIT_W-1:0] lim);
		case ($urandom_range(0, 4))
			0: return 64'd0;
			1: return {48'd0, lim};
			2: return {48'd0, lim} - 1;
			3: return {48'd0, lim} + 1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// at most four entries per list are written out; a longer list ends the buffer early
	task automatic build_tx(input logic [63:0] in_cnt, input logic [63:0] out_cnt,
		input int max_len);
		logic [63:0] len;
		int i;
		tx_buf.delete();
		add_bytes(4, -1);
		add_varint(in_cnt);
		for (i = 0; i < 4 && i < in_cnt; i++) begin
			add_bytes(36, -1);
			len = pick_script_len(max_len);
			add_varint(len);
			if (len > 16) begin
				add_bytes(5, -1);
				return;
			end
			add_bytes(int'(len), -1);
			add_bytes(4, -1);
		end
		if (in_cnt > 4)
			return;
		add_varint(out_cnt);
		for (i = 0; i < 4 && i < out_cnt; i++) begin
			add_bytes(8, value_fill);
			len = pick_script_len(max_len);
			add_varint(len);
			if (len > 16) begin
				add_bytes(5, -1);
				return;
			end
			add_bytes(int'(len), -1);
		end
		if (out_cnt > 4)
			return;
		add_bytes(4, -1);
	endtask

	// channel drivers
	task automatic send_byte(input logic [DATA_W-1:0] b, input logic fin);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		repeat (gap) begin
			@(negedge clk);
			byte_ch.valid <= 1'b0;
		end
		@(negedge clk);
		byte_ch.valid      <= 1'b1;
		byte_ch.data_byte  <= b;
		byte_ch.final_byte <= fin;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		walk_tx_byte(b, fin);
		bytes_sent++;
	endtask

	task automatic send_tx(input int n);
		int i;
		for (i = 0; i < n; i++)
			send_byte(tx_buf[i], i == n - 1);
	endtask

	task automatic send_all();
		send_tx(tx_buf.size());
	endtask

	task automatic settle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_INPUT_LIMIT)
			in_limit = v;
		else
			out_limit = v;
	endtask

	// event receiver: per-event stall plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_len > 0) begin
			hold_len--;
			evt_ch.ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			evt_ch.ready <= 1'b0;
		end else begin
			evt_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && evt_ch.valid && evt_ch.ready) begin
			rx_wait = idle_on ? $urandom_range(0, 3) : 0;
			if (pending_events.size() == 0) begin
				$error("unexpected event: kind %0d value %0h entry %0d",
					evt_ch.event_kind, evt_ch.event_value, evt_ch.entry_number);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				if (evt_ch.event_kind !== want.kind) begin
					$error("event_kind expected %0d actual %0d", want.kind, evt_ch.event_kind);
					mismatches++;
				end
				if (evt_ch.event_value !== want.value) begin
					$error("event_value expected %0h actual %0h", want.value,
						evt_ch.event_value);
					mismatches++;
				end
				if (evt_ch.entry_number !== want.entry) begin
					$error("entry_number expected %0d actual %0d", want.entry,
						evt_ch.entry_number);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// tests
	task automatic test_well_formed();
		idle_on = 1'b0;
		varint_width = 1;
		build_tx(1, 1, 0);
		send_all();
		build_tx(3, 2, 3);
		send_all();
		value_fill = 0;
		build_tx(1, 1, 1);
		send_all();
		value_fill = 8'hFF;
		build_tx(1, 2, 0);
		send_all();
		value_fill = -1;
		varint_width = 0;
		settle();
	endtask

	task automatic test_varint_forms();
		varint_width = 3;
		build_tx(2, 2, 2);
		send_all();
		varint_width = 5;
		build_tx(1, 2, 2);
		send_all();
		varint_width = 9;
		build_tx(2, 1, 2);
		send_all();
		varint_width = 0;
		settle();
	endtask

	task automatic test_bad_counts();
		varint_width = 1;
		build_tx(0, 1, 0);
		send_all();
		build_tx({48'd0, INPUT_LIMIT_RST}, 1, 0);
		send_all();
		build_tx({48'd0, INPUT_LIMIT_RST} - 1, 1, 0);
		send_all();
		build_tx(1, 0, 0);
		send_all();
		build_tx(1, {48'd0, OUTPUT_LIMIT_RST}, 0);
		send_all();
		build_tx(1, 64'hFFFF_FFFF_FFFF_FFFF, 0);
		send_all();
		// final flag on the zero output count itself
		build_tx(1, 0, 0);
		send_tx(47);
		// bytes after the lock time are ignored, so is their final byte
		build_tx(1, 1, 0);
		add_bytes(3, -1);
		send_all();
		varint_width = 0;
		settle();
	endtask

	task automatic test_truncation();
		idle_on = 1'b1;
		build_tx(2, 2, 4);
		send_tx(1);
		build_tx(2, 2, 4);
		send_tx($urandom_range(2, tx_buf.size() - 1));
		build_tx(1, 1, 2);
		send_tx(tx_buf.size() - 1);
		varint_width = 9;
		build_tx(1, 1, 0);
		send_tx(7);
		varint_width = 0;
		build_tx(1, 1, -1);
		send_all();
		settle();
	endtask

	task automatic test_limit_extremes();
		idle_on = 1'b0;
		set_limit(REG_INPUT_LIMIT, '0);
		set_limit(REG_OUTPUT_LIMIT, '0);
		build_tx(1, 1, 0);
		send_all();
		settle();
		set_limit(REG_INPUT_LIMIT, 16'd1);
		build_tx(1, 1, 0);
		send_all();
		settle();
		set_limit(REG_INPUT_LIMIT, 16'd2);
		set_limit(REG_OUTPUT_LIMIT, 16'd1);
		build_tx(1, 1, 0);
		send_all();
		settle();
		set_limit(REG_INPUT_LIMIT, 16'hFFFF);
		set_limit(REG_OUTPUT_LIMIT, 16'hFFFF);
		build_tx(64'd65535, 1, 0);
		send_all();
		build_tx(64'd65534, 1, 0);
		send_all();
		build_tx(1, 64'd65535, 0);
		send_all();
		build_tx(1, 64'd65534, 1);
		send_all();
		settle();
	endtask

	task automatic test_backpressure();
		idle_on = 1'b0;
		hold_len = 300;
		build_tx(2, 4, 0);
		send_all();
		build_tx(1, 3, 1);
		send_all();
		settle();
	endtask

	task automatic test_random_traffic();
		int p;
		int start;
		int sel;
		int n;
		logic [63:0] in_cnt;
		logic [63:0] out_cnt;
		for (p = 0; p < 4; p++) begin
			case (p)
				0: begin
					set_limit(REG_INPUT_LIMIT, INPUT_LIMIT_RST);
					set_limit(REG_OUTPUT_LIMIT, OUTPUT_LIMIT_RST);
				end
				1: begin
					set_limit(REG_INPUT_LIMIT, 16'd3);
					set_limit(REG_OUTPUT_LIMIT, 16'd2);
				end
				2: begin
					set_limit(REG_INPUT_LIMIT, LIMIT_W'($urandom_range(1, 65535)));
					set_limit(REG_OUTPUT_LIMIT, LIMIT_W'($urandom_range(1, 65535)));
				end
				default: begin
					set_limit(REG_INPUT_LIMIT, 16'hFFFF);
					set_limit(REG_OUTPUT_LIMIT, 16'd1);
				end
			endcase
			start = bytes_sent;
			while (bytes_sent - start < 100) begin
				idle_on = ($urandom_range(0, 3) != 0);
				sel = $urandom_range(0, 19);
				in_cnt = $urandom_range(1, 3);
				out_cnt = $urandom_range(1, 3);
				if (sel == 0)
					in_cnt = pick_count(in_limit);
				else if (sel == 1)
					out_cnt = pick_count(out_limit);
				build_tx(in_cnt, out_cnt, $urandom_range(0, 6));
				n = tx_buf.size();
				if (sel == 2 || sel == 3) begin
					n = $urandom_range(1, n);
				end else if (sel == 4) begin
					tx_buf.delete();
					add_bytes($urandom_range(1, 12), -1);
					n = tx_buf.size();
				end else if (sel == 5) begin
					add_bytes($urandom_range(1, 4), -1);
					n = tx_buf.size();
				end
				send_tx(n);
			end
			settle();
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		byte_ch.valid      = 1'b0;
		byte_ch.data_byte  = '0;
		byte_ch.final_byte = 1'b0;
		in_limit           = INPUT_LIMIT_RST;
		out_limit          = OUTPUT_LIMIT_RST;
		clear_walk();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_well_formed();
		test_varint_forms();
		test_bad_counts();
		test_truncation();
		test_backpressure();
		test_limit_extremes();
		test_random_traffic();

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/btxp_pkg.sv
rtl/btxp_if.sv
rtl/btxp_cfg.sv
rtl/btxp_core.sv
rtl/btxp_out_reg.sv
rtl/bitcoin_tx_stream_parser.sv
tb/tb_bitcoin_tx_stream_parser.sv
